[sv/grc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table of the grid ray fan caster.
// No dependencies; every other file of the block refers to this package by scoped names.
package grc_pkg;

  localparam int MAX_RAYS_DEF  = 64;
  localparam int MAX_STEPS_DEF = 2048;
  localparam int MAP_SIZE_DEF  = 16;
  localparam int CELL_SIZE_DEF = 64;

  localparam int GRID_W    = 4;
  localparam int HIT_W     = 18;
  localparam int HIT_MAX   = 262143;
  localparam int QTR       = 1024;
  localparam int ROM_AW    = 11;
  localparam int TRIG_W    = 16;
  localparam int FOV_W     = 15;
  localparam int RCNT_W    = 7;
  localparam int PADDR_W   = 6;
  localparam int PDATA_W   = 64;
  localparam int FOV_RST   = 10430;
  localparam int RCNT_RST  = 64;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [2:0] {
    REG_WALL0 = 3'd0,
    REG_WALL1 = 3'd1,
    REG_WALL2 = 3'd2,
    REG_WALL3 = 3'd3,
    REG_FOV   = 3'd4,
    REG_RAYS  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [15:0] view_angle;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]       ray_index;
    logic [HIT_W-1:0] hit_x;
    logic [HIT_W-1:0] hit_y;
    logic             no_hit;
    logic             last_ray;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic advance;
  } march_ctrl_t;

  typedef struct packed {
    logic             off_map;
    logic             wall;
    logic [HIT_W-1:0] hit_x;
    logic [HIT_W-1:0] hit_y;
  } march_stat_t;

  typedef logic [TRIG_W-1:0] qsin_tab_t [0:QTR];

  // Quarter-wave sine in Q1.15 from a truncated integer Taylor series.
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t   tab;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    for (int k = 0; k <= QTR; k++) begin
      th   = (64'(k) * TWO_PI_Q30) >> 12;
      th2  = (th * th) >> 30;
      sum  = th;
      term = th;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[k] = v[TRIG_W-1:0];
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

endpackage

[sv/grc_march.sv]
`timescale 1ns / 1ps
// Ray marching datapath: the x and y sample accumulators, the cell lookup and the wall test.
// Depends on grc_pkg for the control and status structs.
module grc_march #(
  parameter int MAP_SIZE  = grc_pkg::MAP_SIZE_DEF,
  parameter int CELL_SIZE = grc_pkg::CELL_SIZE_DEF
) (
  input  logic                                clk,
  input  grc_pkg::march_ctrl_t                ctrl,
  input  logic [9:0]                          pos_x,
  input  logic [9:0]                          pos_y,
  input  logic signed [grc_pkg::TRIG_W-1:0]   step_x,
  input  logic signed [grc_pkg::TRIG_W-1:0]   step_y,
  input  logic [255:0]                        wall_map,
  output grc_pkg::march_stat_t                stat
);

  localparam int MAP_PX = MAP_SIZE * CELL_SIZE;
  localparam int PIX_W  = ($clog2(MAP_PX + 1) > 10) ? $clog2(MAP_PX + 1) : 10;
  localparam int PW     = PIX_W + 17;
  localparam int PXW    = PW - 16;
  localparam int QW     = PW - 8;

  logic signed [PW-1:0]       px;
  logic signed [PW-1:0]       py;
  logic [PXW-1:0]             pix_x;
  logic [PXW-1:0]             pix_y;
  logic [grc_pkg::GRID_W-1:0] col;
  logic [grc_pkg::GRID_W-1:0] row;
  logic [QW-1:0]              qx;
  logic [QW-1:0]              qy;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      px <= $signed({{(PW-25){1'b0}}, pos_x, 15'b0});
      py <= $signed({{(PW-25){1'b0}}, pos_y, 15'b0});
    end else if (ctrl.advance) begin
      px <= px + PW'(step_x);
      py <= py + PW'(step_y);
    end
  end

  assign pix_x = px[PW-2:15];
  assign pix_y = py[PW-2:15];
  assign qx    = px[PW-2:7];
  assign qy    = py[PW-2:7];

  always_comb begin
    col = '0;
    row = '0;
    for (int k = 1; k < MAP_SIZE; k++) begin
      if (pix_x >= PXW'(k * CELL_SIZE)) begin
        col = col + 1'b1;
      end
      if (pix_y >= PXW'(k * CELL_SIZE)) begin
        row = row + 1'b1;
      end
    end
  end

  always_comb begin
    stat.off_map = px[PW-1] || py[PW-1] ||
                   (pix_x >= PXW'(MAP_PX)) || (pix_y >= PXW'(MAP_PX));
    stat.wall    = wall_map[{row, col}];
    stat.hit_x   = (qx > QW'(grc_pkg::HIT_MAX)) ? grc_pkg::HIT_W'(grc_pkg::HIT_MAX)
                                                 : qx[grc_pkg::HIT_W-1:0];
    stat.hit_y   = (qy > QW'(grc_pkg::HIT_MAX)) ? grc_pkg::HIT_W'(grc_pkg::HIT_MAX)
                                                 : qy[grc_pkg::HIT_W-1:0];
  end

endmodule

[sv/grid_ray_fan_caster_unit.sv]
`timescale 1ns / 1ps
// Top level of the grid ray fan caster: configuration registers, sequencer, divider and sine ROM.
// Depends on grc_pkg and instantiates grc_march.
//
// One request casts a fan of rays and returns one beat per ray, in ray order. The block takes
// one request at a time and is not ready until the last ray's beat has been taken. A request
// is taken in the idle state, then the fan spacing divider yields one quotient bit per cycle.
// Per ray, the sine and cosine lookups in the single-port table run through the sin, cos and
// load states, the march tests one sample per cycle (at most MAX_STEPS samples), and the result
// beat is handed over in the out state, where it waits for out_ready. The march loop sets the
// run time.
module grid_ray_fan_caster_unit #(
  parameter int MAX_RAYS  = grc_pkg::MAX_RAYS_DEF,
  parameter int MAX_STEPS = grc_pkg::MAX_STEPS_DEF,
  parameter int MAP_SIZE  = grc_pkg::MAP_SIZE_DEF,
  parameter int CELL_SIZE = grc_pkg::CELL_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  grc_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output grc_pkg::out_beat_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grc_pkg::PADDR_W-1:0]   paddr,
  input  logic [grc_pkg::PDATA_W-1:0]   pwdata,
  output logic [grc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int LEN_W = $clog2(MAX_STEPS);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_STEPS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_SIN   = 7'b0000100,
    S_COS   = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_MARCH = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                                state;
  logic [63:0]                           wall0;
  logic [63:0]                           wall1;
  logic [63:0]                           wall2;
  logic [63:0]                           wall3;
  logic [grc_pkg::FOV_W-1:0]             fov;
  logic [grc_pkg::RCNT_W-1:0]            ray_cnt;
  logic [grc_pkg::RCNT_W-1:0]            n_eff;
  logic                                  cfg_wr;
  grc_pkg::reg_idx_t                     cfg_idx;

  logic [9:0]                            pos_x;
  logic [9:0]                            pos_y;
  logic [3:0]                            div_cnt;
  logic [grc_pkg::RCNT_W-1:0]            rem;
  logic [grc_pkg::FOV_W-1:0]             dvd;
  logic [grc_pkg::RCNT_W:0]              div_try;
  logic [15:0]                           ang;
  logic [15:0]                           rom_ang;
  logic [11:0]                           rom_idx;
  logic [grc_pkg::ROM_AW-1:0]            rom_addr;
  logic [grc_pkg::TRIG_W-1:0]            rom_q;
  logic                                  rom_neg;
  logic signed [grc_pkg::TRIG_W-1:0]     trig_v;
  logic signed [grc_pkg::TRIG_W-1:0]     sin_v;
  logic signed [grc_pkg::TRIG_W-1:0]     cos_v;
  logic [5:0]                            ray;
  logic                                  last;
  logic [LEN_W-1:0]                      len;
  logic                                  march_done;
  grc_pkg::march_ctrl_t                  mctrl;
  grc_pkg::march_stat_t                  mstat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = grc_pkg::reg_idx_t'(paddr[grc_pkg::PADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wall0   <= '0;
      wall1   <= '0;
      wall2   <= '0;
      wall3   <= '0;
      fov     <= grc_pkg::FOV_W'(grc_pkg::FOV_RST);
      ray_cnt <= grc_pkg::RCNT_W'(grc_pkg::RCNT_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        grc_pkg::REG_WALL0: wall0   <= pwdata;
        grc_pkg::REG_WALL1: wall1   <= pwdata;
        grc_pkg::REG_WALL2: wall2   <= pwdata;
        grc_pkg::REG_WALL3: wall3   <= pwdata;
        grc_pkg::REG_FOV:   fov     <= pwdata[grc_pkg::FOV_W-1:0];
        grc_pkg::REG_RAYS:  ray_cnt <= pwdata[grc_pkg::RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      grc_pkg::REG_WALL0: prdata = wall0;
      grc_pkg::REG_WALL1: prdata = wall1;
      grc_pkg::REG_WALL2: prdata = wall2;
      grc_pkg::REG_WALL3: prdata = wall3;
      grc_pkg::REG_FOV:   prdata = grc_pkg::PDATA_W'(fov);
      grc_pkg::REG_RAYS:  prdata = grc_pkg::PDATA_W'(ray_cnt);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    priority if (ray_cnt == '0) begin
      n_eff = grc_pkg::RCNT_W'(1);
    end else if (ray_cnt > grc_pkg::RCNT_W'(MAX_RAYS)) begin
      n_eff = grc_pkg::RCNT_W'(MAX_RAYS);
    end else begin
      n_eff = ray_cnt;
    end
  end

  assign div_try = {rem, dvd[grc_pkg::FOV_W-1]};
  assign last    = ({1'b0, ray} == n_eff - 1'b1);

  // The table holds a quarter wave; the upper index bits pick the mirror and the sign.
  assign rom_ang  = (state == S_COS) ? ang + 16'd16384 : ang;
  assign rom_idx  = rom_ang[15:4];
  assign rom_addr = rom_idx[10] ? grc_pkg::ROM_AW'(grc_pkg::QTR - int'(rom_idx[9:0]))
                                : {1'b0, rom_idx[9:0]};
  assign trig_v   = rom_neg ? -$signed(rom_q) : $signed(rom_q);

  always_ff @(posedge clk) begin
    rom_q   <= grc_pkg::QSIN_TAB[rom_addr];
    rom_neg <= rom_idx[11];
  end

  assign in_ready   = (state == S_IDLE);
  assign march_done = mstat.off_map || mstat.wall || (len == LEN_LAST);
  assign mctrl.load    = (state == S_LOAD);
  assign mctrl.advance = (state == S_MARCH) && !march_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pos_x   <= in_data.pos_x;
            pos_y   <= in_data.pos_y;
            ang     <= in_data.view_angle - {1'b0, fov[grc_pkg::FOV_W-1:1]};
            dvd     <= fov;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_try >= {1'b0, n_eff}) begin
            rem <= grc_pkg::RCNT_W'(div_try - {1'b0, n_eff});
            dvd <= {dvd[grc_pkg::FOV_W-2:0], 1'b1};
          end else begin
            rem <= div_try[grc_pkg::RCNT_W-1:0];
            dvd <= {dvd[grc_pkg::FOV_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 4'(grc_pkg::FOV_W - 1)) begin
            ray   <= '0;
            state <= S_SIN;
          end
        end
        S_SIN: begin
          state <= S_COS;
        end
        S_COS: begin
          sin_v <= trig_v;
          state <= S_LOAD;
        end
        S_LOAD: begin
          cos_v <= trig_v;
          len   <= '0;
          state <= S_MARCH;
        end
        S_MARCH: begin
          if (march_done) begin
            out_data.ray_index <= ray;
            out_data.no_hit    <= !(mstat.wall && !mstat.off_map);
            out_data.hit_x     <= (mstat.wall && !mstat.off_map) ? mstat.hit_x : '0;
            out_data.hit_y     <= (mstat.wall && !mstat.off_map) ? mstat.hit_y : '0;
            out_data.last_ray  <= last;
            out_valid          <= 1'b1;
            state              <= S_OUT;
          end else begin
            len <= len + 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_data.last_ray) begin
              state <= S_IDLE;
            end else begin
              ray   <= ray + 1'b1;
              ang   <= ang + {1'b0, dvd};
              state <= S_SIN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  grc_march #(
    .MAP_SIZE  (MAP_SIZE),
    .CELL_SIZE (CELL_SIZE)
  ) u_march (
    .clk      (clk),
    .ctrl     (mctrl),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .step_x   (cos_v),
    .step_y   (sin_v),
    .wall_map ({wall3, wall2, wall1, wall0}),
    .stat     (mstat)
  );

  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("Input ready while a result beat is pending.");

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_ray |-> {1'b0, out_data.ray_index} == n_eff - 1'b1)
    else $error("Final ray flag on a beat that is not the final ray.");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.no_hit |-> out_data.hit_x == '0 && out_data.hit_y == '0)
    else $error("Miss beat carries a nonzero hit point.");

  a_fan_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_ray |=> in_ready)
    else $error("Block not ready after the final ray beat was taken.");

endmodule
